// ----- rtl/core/sip24_pkg.sv -----
// SipHash-2-4 shared types, constants and half-round functions.
// No dependencies; used by every module of the hash core.
package sip24_pkg;

    localparam logic [63:0] SIP_C0    = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1    = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2    = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3    = 64'h7465646279746573;
    localparam logic [7:0]  MSG_LEN   = 8'd12;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    localparam int WORD_W  = 32;
    localparam int HASH_W  = 64;
    localparam int TDATA_W = 3 * WORD_W;
    localparam int KEY_W   = 64;

    // Configuration register indexes
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] v3;
        logic [63:0] v2;
        logic [63:0] v1;
        logic [63:0] v0;
    } sip24_state_t;

    // The two 64-bit message words of the 12-byte message
    typedef struct packed {
        logic [63:0] last;
        logic [63:0] block;
    } sip24_msg_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned s);
        rotl64 = (x << s) | (x >> (64 - s));
    endfunction

    // First half of SipRound: one add on each pair
    function automatic sip24_state_t half_a(input sip24_state_t v);
        sip24_state_t r;
        r    = v;
        r.v0 = v.v0 + v.v1;
        r.v1 = rotl64(v.v1, 13) ^ r.v0;
        r.v0 = rotl64(r.v0, 32);
        r.v2 = v.v2 + v.v3;
        r.v3 = rotl64(v.v3, 16) ^ r.v2;
        return r;
    endfunction

    // Second half of SipRound
    function automatic sip24_state_t half_b(input sip24_state_t v);
        sip24_state_t r;
        r    = v;
        r.v0 = v.v0 + v.v3;
        r.v3 = rotl64(v.v3, 21) ^ r.v0;
        r.v2 = v.v2 + v.v1;
        r.v1 = rotl64(v.v1, 17) ^ r.v2;
        r.v2 = rotl64(r.v2, 32);
        return r;
    endfunction

endpackage

// ----- rtl/core/sip24_front.sv -----
// Input side of the hash core: takes a transfer and forms the message words.
// Depends on sip24_pkg.
module sip24_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sip24_pkg::TDATA_W-1:0] s_tdata,   // word_a, word_b, word_c
    output logic                          q_valid,
    input  logic                          q_ready,
    output sip24_pkg::sip24_msg_t         q_msg
);

    logic                  valid_reg, valid_next;
    sip24_pkg::sip24_msg_t msg_reg, msg_next;
    logic                  take;

    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
        msg_next.block = s_tdata[63:0];
        // length in the top byte, tail bytes at the bottom
        msg_next.last  = {sip24_pkg::MSG_LEN, 24'h000000, s_tdata[95:64]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            msg_reg <= msg_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_msg   = msg_reg;

endmodule

// ----- rtl/core/sip24_queue.sv -----
// Short queue between the input side and the round pipeline.
// Depends on sip24_pkg.
module sip24_queue #(
    parameter int ADDR_W = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sip24_pkg::sip24_msg_t in_msg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sip24_pkg::sip24_msg_t out_msg
);

    localparam int DEPTH = 1 << ADDR_W;

    sip24_pkg::sip24_msg_t mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != DEPTH[ADDR_W:0]);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_msg   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_msg;
        end
    end

endmodule

// ----- rtl/core/sip24_back.sv -----
// Round pipeline: one SipRound half per stage, then the output register.
// Depends on sip24_pkg.
module sip24_back #(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sip24_pkg::KEY_W-1:0]  key_low,
    input  logic [sip24_pkg::KEY_W-1:0]  key_high,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  sip24_pkg::sip24_msg_t        q_msg,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sip24_pkg::HASH_W-1:0] m_tdata      // hash_value
);

    localparam int NUM_STAGES = 2 * (2 * COMPRESS_ROUNDS + FINAL_ROUNDS);

    sip24_pkg::sip24_state_t v_reg   [NUM_STAGES];
    sip24_pkg::sip24_msg_t   msg_reg [NUM_STAGES];
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES:0]     rdy;

    logic                         out_valid_reg, out_valid_next;
    logic [sip24_pkg::HASH_W-1:0] hash_reg, hash_next;

    assign rdy[NUM_STAGES] = !out_valid_reg || m_tready;
    assign q_ready         = rdy[0];

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        localparam int RND = k / 2;

        sip24_pkg::sip24_state_t st_in, st_mix, st_out;
        sip24_pkg::sip24_msg_t   msg_in;
        logic                    vin;

        if (k == 0) begin : g_first
            always_comb begin
                vin      = q_valid;
                msg_in   = q_msg;
                st_in.v0 = sip24_pkg::SIP_C0 ^ key_low;
                st_in.v1 = sip24_pkg::SIP_C1 ^ key_high;
                st_in.v2 = sip24_pkg::SIP_C2 ^ key_low;
                st_in.v3 = sip24_pkg::SIP_C3 ^ key_high;
            end
        end else begin : g_rest
            always_comb begin
                vin    = vld_reg[k-1];
                msg_in = msg_reg[k-1];
                st_in  = v_reg[k-1];
            end
        end

        // message injection sits at round boundaries
        always_comb begin
            st_mix = st_in;
            if (k % 2 == 0) begin
                if (RND == 0) begin
                    st_mix.v3 = st_in.v3 ^ msg_in.block;
                end else if (RND == COMPRESS_ROUNDS) begin
                    st_mix.v0 = st_in.v0 ^ msg_in.block;
                    st_mix.v3 = st_in.v3 ^ msg_in.last;
                end else if (RND == 2 * COMPRESS_ROUNDS) begin
                    st_mix.v0 = st_in.v0 ^ msg_in.last;
                    st_mix.v2 = st_in.v2 ^ sip24_pkg::FINAL_XOR;
                end
                st_out = sip24_pkg::half_a(st_mix);
            end else begin
                st_out = sip24_pkg::half_b(st_mix);
            end
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && vin) begin
                v_reg[k]   <= st_out;
                msg_reg[k] <= msg_in;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (rdy[NUM_STAGES]) begin
            out_valid_next = vld_reg[NUM_STAGES-1];
        end
        hash_next = v_reg[NUM_STAGES-1].v0 ^ v_reg[NUM_STAGES-1].v1
                  ^ v_reg[NUM_STAGES-1].v2 ^ v_reg[NUM_STAGES-1].v3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NUM_STAGES] && vld_reg[NUM_STAGES-1]) begin
            hash_reg <= hash_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hash_reg;

endmodule

// ----- rtl/core/siphash24_three_word_hash_core.sv -----
// Keyed SipHash-2-4 of a 12-byte message given as three 32-bit words. One transfer
// on the s_ side gives one 64-bit hash on the m_ side, in order. The core takes one
// item every clock cycle while m_tready does not hold it back. An item passes one input
// register, the queue, one pipeline stage per SipRound half (two 64-bit adds with their
// rotates and xors each) and the output register. The key is written through
// cfg_wr_en/cfg_index/cfg_wr_data (index 0 key_low, index 1 key_high); both reset to zero.
// The user must write it only while no hash is in flight; the core does not enforce this.
// Top level; depends on sip24_pkg, sip24_front, sip24_queue and sip24_back.
module siphash24_three_word_hash_core #(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 4,
    parameter int QUEUE_ADDR_W    = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [sip24_pkg::KEY_W-1:0]   cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sip24_pkg::TDATA_W-1:0] s_tdata,   // word_a, word_b, word_c
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sip24_pkg::HASH_W-1:0]  m_tdata    // hash_value
);

    logic [sip24_pkg::KEY_W-1:0] key_low_reg, key_low_next;
    logic [sip24_pkg::KEY_W-1:0] key_high_reg, key_high_next;

    logic                  fr_valid, fr_ready;
    sip24_pkg::sip24_msg_t fr_msg;
    logic                  q_valid, q_ready;
    sip24_pkg::sip24_msg_t q_msg;

    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                sip24_pkg::REG_KEY_LOW:  key_low_next  = cfg_wr_data;
                sip24_pkg::REG_KEY_HIGH: key_high_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    sip24_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fr_valid),
        .q_ready  (fr_ready),
        .q_msg    (fr_msg)
    );

    sip24_queue #(
        .ADDR_W (QUEUE_ADDR_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_msg    (fr_msg),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_msg   (q_msg)
    );

    sip24_back #(
        .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_msg    (q_msg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
